>>> design/obht_pkg.sv
package obht_pkg;

	localparam int SLOTS       = 8;
	localparam int LABEL_BYTES = 8;
	localparam int NUM_BUCKETS = 256;
	localparam int ENTRIES     = NUM_BUCKETS * SLOTS;
	localparam int BKT_W       = 8;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int ENT_AW      = $clog2(ENTRIES);
	localparam int LBL_W       = 64;
	localparam int LEN_W       = 4;
	localparam int VAL_W       = 4;
	localparam int BI_W        = $clog2(LABEL_BYTES + 1);
	localparam int PWR_W       = 24;
	localparam int PROD_W      = BKT_W + 1 + VAL_W;

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_REPORT = 2'd2
	} op_e;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_CRD, S_CGET, S_SRD, S_SCMP, S_INS, S_SHRD, S_SHWR,
		S_RMFIN, S_RCRD, S_RCGET, S_RRD, S_RMUL, S_RACC, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [LBL_W-1:0] label;
		logic [LEN_W-1:0] label_length;
		logic [VAL_W-1:0] focal_value;
	} in_t;

	typedef struct packed {
		logic [7:0]       step_hash;
		logic [BKT_W-1:0] bucket;
		logic             found;
		logic [2:0]       slot;
		logic             bucket_full;
		logic [PWR_W-1:0] total_power;
	} out_t;

	typedef struct packed {
		logic [LBL_W-1:0] lab;
		logic [LEN_W-1:0] len;
		logic [VAL_W-1:0] val;
	} ent_t;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic cnt_rd;
		logic cnt_cap;
		logic ent_rd;
		logic hit_set;
		logic slot_inc;
		logic ins_wr;
		logic shift_wr;
		logic cnt_dec;
		logic rb_inc;
		logic rpt_mul;
		logic rpt_acc;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic hash_more;
		logic slot_more;
		logic match;
		logic is_insert;
		logic is_report;
		logic rb_last;
	} sts_t;

	function automatic logic [7:0] hash_byte(input logic [7:0] h, input logic [7:0] b);
		logic [7:0] s;
		s = h + b;
		return s + {s[3:0], 4'b0000};
	endfunction

	function automatic logic [ENT_AW-1:0] ent_addr(input logic [BKT_W-1:0] b,
		input logic [SLOT_W-1:0] s);
		return ENT_AW'(int'(b) * SLOTS + int'(s));
	endfunction

endpackage

>>> design/ordered_bucket_hash_table.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   in_t  (op, label, label_length, focal_value)
// rsp      out        rsp_valid/rsp_stall   out_t (step_hash .. total_power)
//
// Insert/remove: accept, hash the label one byte at a time, read the bucket count, walk
// the slots (search, then shift down on remove), update the entry or the count, then finish.
// Report: accept, decode, then for all 256 buckets read the count and, for each stored
// entry, read it, multiply and accumulate; finish with the output load.
// Reset clears the state machine, output valid and per-bucket count valid bits.
// One transaction in flight; a result held by rsp_stall only delays the final output load.
module ordered_bucket_hash_table import obht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output out_t rsp
);

	cmd_t cmd;
	sts_t sts;
	out_t res;
	out_t rsp_q;
	logic rsp_vld_q;
	logic out_free;

	// output register frees up as soon as its transaction is taken
	assign out_free = !rsp_vld_q || !rsp_stall;

	obht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	obht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

>>> design/obht_ctrl.sv
module obht_ctrl import obht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic out_free,
	input  sts_t sts,
	output logic req_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.is_report) begin
					state_d = S_RCRD;
				end else if (sts.hash_more) begin
					cmd.hash_step = 1'b1;
				end else begin
					state_d = S_CRD;
				end
			end
			S_CRD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_CGET;
			end
			S_CGET: begin
				cmd.cnt_cap = 1'b1;
				state_d     = S_SRD;
			end
			S_SRD: begin
				if (sts.slot_more) begin
					cmd.ent_rd = 1'b1;
					state_d    = S_SCMP;
				end else begin
					state_d = sts.is_insert ? S_INS : S_DONE;
				end
			end
			S_SCMP: begin
				if (sts.match) begin
					cmd.hit_set = 1'b1;
					state_d     = sts.is_insert ? S_INS : S_SHRD;
				end else begin
					cmd.slot_inc = 1'b1;
					state_d      = S_SRD;
				end
			end
			S_INS: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_SHRD: begin
				if (sts.slot_more) begin
					cmd.ent_rd = 1'b1;
					state_d    = S_SHWR;
				end else begin
					state_d = S_RMFIN;
				end
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				cmd.slot_inc = 1'b1;
				state_d      = S_SHRD;
			end
			S_RMFIN: begin
				cmd.cnt_dec = 1'b1;
				state_d     = S_DONE;
			end
			S_RCRD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_RCGET;
			end
			S_RCGET: begin
				cmd.cnt_cap = 1'b1;
				state_d     = S_RRD;
			end
			S_RRD: begin
				if (sts.slot_more) begin
					cmd.ent_rd = 1'b1;
					state_d    = S_RMUL;
				end else if (sts.rb_last) begin
					state_d = S_DONE;
				end else begin
					cmd.rb_inc = 1'b1;
					state_d    = S_RCRD;
				end
			end
			S_RMUL: begin
				cmd.rpt_mul = 1'b1;
				state_d     = S_RACC;
			end
			S_RACC: begin
				cmd.rpt_acc  = 1'b1;
				cmd.slot_inc = 1'b1;
				state_d      = S_RRD;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> design/obht_dp.sv
module obht_dp import obht_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  in_t  req,
	output sts_t sts,
	output out_t res
);

	// entry store and bucket fill counts
	ent_t             ent_mem [ENTRIES];
	logic [CNT_W-1:0] cnt_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] cnt_vld_q;

	ent_t             rd_q;
	logic [CNT_W-1:0] cnt_rd_q;
	logic             cvld_rd_q;

	logic [1:0]        op_q;
	logic [LBL_W-1:0]  lab_q;
	logic [LEN_W-1:0]  len_q;
	logic [VAL_W-1:0]  val_q;
	logic [7:0]        h_q;
	logic [BI_W-1:0]   bi_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  i_q;
	logic              hit_q;
	logic [SLOT_W-1:0] pos_q;
	logic [BKT_W-1:0]  rb_q;
	logic [PROD_W-1:0] prod_q;
	logic [PWR_W-1:0]  acc_q;

	logic [LEN_W-1:0]  len_c;
	logic [LBL_W-1:0]  lab_c;
	logic [7:0]        byte_c;
	logic [BKT_W-1:0]  cb;
	logic              is_ins, is_rpt, full_c;
	logic [CNT_W-1:0]  cnt_c;
	logic              ent_we, cnt_we;
	logic [ENT_AW-1:0] ent_wa;
	ent_t              ent_wd;
	logic [CNT_W-1:0]  cnt_wd;
	logic [PWR_W:0]    sum_c;

	always_comb begin
		len_c = (req.label_length > LEN_W'(LABEL_BYTES)) ? LEN_W'(LABEL_BYTES)
			: req.label_length;
		for (int k = 0; k < LBL_W / 8; k++) begin
			lab_c[8*k +: 8] = (LEN_W'(k) < len_c) ? req.label[8*k +: 8] : 8'h00;
		end
	end

	assign byte_c = 8'(lab_q >> {bi_q, 3'b000});
	assign is_ins = (op_q == OP_INSERT);
	assign is_rpt = !(op_q == OP_INSERT || op_q == OP_REMOVE);
	assign cb     = is_rpt ? rb_q : h_q;
	assign full_c = (cnt_q >= CNT_W'(SLOTS));
	assign cnt_c  = cvld_rd_q ? ((cnt_rd_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cnt_rd_q)
		: '0;
	assign sum_c  = (PWR_W+1)'(acc_q)
		+ (PWR_W+1)'(prod_q) * ((PWR_W+1)'(i_q) + (PWR_W+1)'(1));

	assign sts.hash_more = (LEN_W'(bi_q) < len_q);
	assign sts.slot_more = (i_q < cnt_q);
	assign sts.match     = (rd_q.len == len_q) && (rd_q.lab == lab_q);
	assign sts.is_insert = is_ins;
	assign sts.is_report = is_rpt;
	assign sts.rb_last   = (rb_q == BKT_W'(NUM_BUCKETS - 1));

	// write port selection
	always_comb begin
		ent_we = 1'b0;
		ent_wa = ent_addr(h_q, pos_q);
		ent_wd = '{lab: lab_q, len: len_q, val: val_q};
		cnt_we = 1'b0;
		cnt_wd = cnt_q + CNT_W'(1);
		if (cmd.ins_wr) begin
			if (hit_q) begin
				ent_we = 1'b1;
			end else if (!full_c) begin
				ent_we = 1'b1;
				ent_wa = ent_addr(h_q, SLOT_W'(cnt_q));
				cnt_we = 1'b1;
			end
		end
		if (cmd.shift_wr) begin
			ent_we = 1'b1;
			ent_wa = ent_addr(h_q, SLOT_W'(i_q - CNT_W'(1)));
			ent_wd = rd_q;
		end
		if (cmd.cnt_dec) begin
			cnt_we = 1'b1;
			cnt_wd = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (cmd.ent_rd) begin
			rd_q <= ent_mem[ent_addr(cb, SLOT_W'(i_q))];
		end
		if (cnt_we) begin
			cnt_mem[h_q] <= cnt_wd;
		end
		if (cmd.cnt_rd) begin
			cnt_rd_q  <= cnt_mem[cb];
			cvld_rd_q <= cnt_vld_q[cb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cnt_we) begin
			cnt_vld_q[h_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.op;
			lab_q  <= lab_c;
			len_q  <= len_c;
			val_q  <= req.focal_value;
			h_q    <= '0;
			bi_q   <= '0;
			hit_q  <= 1'b0;
			pos_q  <= '0;
			rb_q   <= '0;
			acc_q  <= '0;
		end
		if (cmd.hash_step) begin
			h_q  <= hash_byte(h_q, byte_c);
			bi_q <= bi_q + BI_W'(1);
		end
		if (cmd.cnt_cap) begin
			cnt_q <= cnt_c;
			i_q   <= '0;
		end
		if (cmd.hit_set) begin
			hit_q <= 1'b1;
			pos_q <= SLOT_W'(i_q);
			i_q   <= i_q + CNT_W'(1);
		end
		if (cmd.slot_inc) begin
			i_q <= i_q + CNT_W'(1);
		end
		if (cmd.rb_inc) begin
			rb_q <= rb_q + BKT_W'(1);
		end
		if (cmd.rpt_mul) begin
			prod_q <= (PROD_W'(rb_q) + PROD_W'(1)) * PROD_W'(rd_q.val);
		end
		if (cmd.rpt_acc) begin
			acc_q <= sum_c[PWR_W] ? '1 : sum_c[PWR_W-1:0];
		end
	end

	always_comb begin
		res = '0;
		if (is_rpt) begin
			res.total_power = acc_q;
		end else begin
			res.step_hash   = is_ins ? hash_byte(hash_byte(h_q, CH_EQ),
				CH_ZERO + 8'(val_q)) : hash_byte(h_q, CH_MINUS);
			res.bucket      = h_q;
			res.found       = hit_q;
			res.bucket_full = is_ins && !hit_q && full_c;
			if (hit_q) begin
				res.slot = 3'(pos_q);
			end else if (is_ins && !full_c) begin
				res.slot = 3'(cnt_q);
			end
		end
	end

endmodule
